// ===== design/signed_decimal_formatter_macros.svh =====
// Assertion macros shared by the signed decimal formatter.
`ifndef SIGNED_DECIMAL_FORMATTER_MACROS_SVH
`define SIGNED_DECIMAL_FORMATTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SDF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define SDF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/sdf_pkg.sv =====
// Types, constants and microcode encodings of the signed decimal formatter.
package sdf_pkg;

   localparam int MAX_WIDTH   = 32;
   localparam int DIGIT_SLOTS = 11;
   localparam int CNT_W       = $clog2(DIGIT_SLOTS + 1);
   localparam int UPC_W       = 3;

   localparam logic [31:0] RECIP       = 32'hCCCC_CCCD;
   localparam int          RECIP_SHIFT = 35;
   localparam logic [7:0]  CHAR_ZERO   = 8'h30;
   localparam logic [7:0]  CHAR_MINUS  = 8'h2D;
   localparam logic [7:0]  CHAR_NINE   = 8'h39;

   typedef struct packed {
      logic signed [31:0] value;
      logic [5:0]         min_width;
      logic [7:0]         pad_char;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       last;
   } rsp_type;

   // Microcode step addresses
   localparam logic [UPC_W-1:0] STEP_IDLE     = 3'd0;
   localparam logic [UPC_W-1:0] STEP_MUL      = 3'd1;
   localparam logic [UPC_W-1:0] STEP_DIGIT    = 3'd2;
   localparam logic [UPC_W-1:0] STEP_SIGN     = 3'd3;
   localparam logic [UPC_W-1:0] STEP_PADS     = 3'd4;
   localparam logic [UPC_W-1:0] STEP_EMIT_PAD = 3'd5;
   localparam logic [UPC_W-1:0] STEP_EMIT_TXT = 3'd6;

   typedef enum logic [1:0] {
      WAIT_NONE,
      WAIT_REQ,
      WAIT_SLOT
   } wait_type;

   typedef enum logic [2:0] {
      ACT_LOAD,
      ACT_MUL,
      ACT_DIGIT,
      ACT_SIGN,
      ACT_PADS,
      ACT_OUT_PAD,
      ACT_OUT_TXT
   } act_type;

   typedef enum logic [2:0] {
      COND_NEVER,
      COND_Q_NZ,
      COND_NO_PAD,
      COND_PAD_MORE,
      COND_TXT_MORE
   } cond_type;

   typedef struct packed {
      wait_type         waits;
      act_type          act;
      cond_type         cond;
      logic [UPC_W-1:0] tgt;
      logic [UPC_W-1:0] nxt;
   } uword_type;

   typedef struct packed {
      act_type act;
      logic    go;
   } ctrl_type;

   typedef struct packed {
      logic slot_free;
      logic q_nz;
      logic no_pad;
      logic pad_more;
      logic txt_more;
   } stat_type;

endpackage

// ===== design/sdf_ucode_rom.sv =====
// Microcode table: one control word per step.
module sdf_ucode_rom (
   input  logic [sdf_pkg::UPC_W-1:0] upc,
   output sdf_pkg::uword_type        uword
);

   always_comb begin
      unique case (upc)
         sdf_pkg::STEP_IDLE: begin
            uword = '{sdf_pkg::WAIT_REQ, sdf_pkg::ACT_LOAD, sdf_pkg::COND_NEVER,
                      sdf_pkg::STEP_IDLE, sdf_pkg::STEP_MUL};
         end
         sdf_pkg::STEP_MUL: begin
            uword = '{sdf_pkg::WAIT_NONE, sdf_pkg::ACT_MUL, sdf_pkg::COND_NEVER,
                      sdf_pkg::STEP_MUL, sdf_pkg::STEP_DIGIT};
         end
         sdf_pkg::STEP_DIGIT: begin
            uword = '{sdf_pkg::WAIT_NONE, sdf_pkg::ACT_DIGIT, sdf_pkg::COND_Q_NZ,
                      sdf_pkg::STEP_MUL, sdf_pkg::STEP_SIGN};
         end
         sdf_pkg::STEP_SIGN: begin
            uword = '{sdf_pkg::WAIT_NONE, sdf_pkg::ACT_SIGN, sdf_pkg::COND_NEVER,
                      sdf_pkg::STEP_SIGN, sdf_pkg::STEP_PADS};
         end
         sdf_pkg::STEP_PADS: begin
            uword = '{sdf_pkg::WAIT_NONE, sdf_pkg::ACT_PADS, sdf_pkg::COND_NO_PAD,
                      sdf_pkg::STEP_EMIT_TXT, sdf_pkg::STEP_EMIT_PAD};
         end
         sdf_pkg::STEP_EMIT_PAD: begin
            uword = '{sdf_pkg::WAIT_SLOT, sdf_pkg::ACT_OUT_PAD, sdf_pkg::COND_PAD_MORE,
                      sdf_pkg::STEP_EMIT_PAD, sdf_pkg::STEP_EMIT_TXT};
         end
         sdf_pkg::STEP_EMIT_TXT: begin
            uword = '{sdf_pkg::WAIT_SLOT, sdf_pkg::ACT_OUT_TXT, sdf_pkg::COND_TXT_MORE,
                      sdf_pkg::STEP_EMIT_TXT, sdf_pkg::STEP_IDLE};
         end
         default: begin
            uword = '{sdf_pkg::WAIT_NONE, sdf_pkg::ACT_LOAD, sdf_pkg::COND_NEVER,
                      sdf_pkg::STEP_IDLE, sdf_pkg::STEP_IDLE};
         end
      endcase
   end

endmodule

// ===== design/sdf_sequencer.sv =====
// Step counter, wait handling and conditional jumps over the microcode table.
module sdf_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  sdf_pkg::stat_type   stat,
   output logic                req_ready,
   output sdf_pkg::ctrl_type   ctrl
);

   logic [sdf_pkg::UPC_W-1:0] upc_ff;
   logic [sdf_pkg::UPC_W-1:0] upc_in;
   sdf_pkg::uword_type        uword;
   logic                      go;
   logic                      taken;

   sdf_ucode_rom u_rom (
      .upc   (upc_ff),
      .uword (uword)
   );

   always_comb begin
      unique case (uword.waits)
         sdf_pkg::WAIT_REQ:  go = req_valid;
         sdf_pkg::WAIT_SLOT: go = stat.slot_free;
         default:            go = 1'b1;
      endcase

      unique case (uword.cond)
         sdf_pkg::COND_Q_NZ:     taken = stat.q_nz;
         sdf_pkg::COND_NO_PAD:   taken = stat.no_pad;
         sdf_pkg::COND_PAD_MORE: taken = stat.pad_more;
         sdf_pkg::COND_TXT_MORE: taken = stat.txt_more;
         default:                taken = 1'b0;
      endcase

      // a waiting step holds until its event arrives
      if (!go) begin
         upc_in = upc_ff;
      end else if (taken) begin
         upc_in = uword.tgt;
      end else begin
         upc_in = uword.nxt;
      end
   end

   assign req_ready = (uword.waits == sdf_pkg::WAIT_REQ);
   assign ctrl      = '{uword.act, go};

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= sdf_pkg::STEP_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ===== design/sdf_datapath.sv =====
// Magnitude, divide-by-ten, text buffer, pad counter and output register.
module sdf_datapath (
   input  logic                clock,
   input  logic                reset,
   input  sdf_pkg::ctrl_type   ctrl,
   input  sdf_pkg::req_type    req_data,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output sdf_pkg::rsp_type    rsp_data,
   output sdf_pkg::stat_type   stat
);

   logic [31:0]               mag_ff;
   logic [31:0]               mag_in;
   logic                      neg_ff;
   logic                      neg_in;
   logic [5:0]                width_ff;
   logic [5:0]                width_in;
   logic [sdf_pkg::CNT_W-1:0] cnt_ff;
   logic [sdf_pkg::CNT_W-1:0] cnt_in;
   logic [63:0]               prod_ff;
   logic [63:0]               prod_in;
   logic [5:0]                pad_ff;
   logic [5:0]                pad_in;
   logic [7:0]                padch_ff;
   logic [7:0]                padch_in;
   logic [7:0]                text_ff [sdf_pkg::DIGIT_SLOTS];
   logic                      text_we;
   logic [7:0]                text_wd;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   sdf_pkg::rsp_type          rsp_ff;
   sdf_pkg::rsp_type          rsp_in;

   logic [31:0]               quot;
   logic [31:0]               quot10;
   logic [31:0]               remd;
   logic [5:0]                cnt_ext;
   logic                      slot_free;
   logic [sdf_pkg::CNT_W-1:0] rd_idx;

   // mag / 10 = (mag * 0xCCCCCCCD) >> 35, exact over 32 bits
   assign quot    = 32'(prod_ff[63:sdf_pkg::RECIP_SHIFT]);
   assign quot10  = (quot << 3) + (quot << 1);
   assign remd    = mag_ff - quot10;
   assign cnt_ext = 6'(cnt_ff);
   assign rd_idx  = cnt_ff - sdf_pkg::CNT_W'(1);

   assign slot_free = !rsp_valid_ff || rsp_ready;

   assign stat.slot_free = slot_free;
   assign stat.q_nz      = (quot != 32'd0);
   assign stat.no_pad    = (width_ff <= cnt_ext);
   assign stat.pad_more  = (pad_ff != 6'd1);
   assign stat.txt_more  = (cnt_ff != sdf_pkg::CNT_W'(1));

   always_comb begin
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      width_in     = width_ff;
      cnt_in       = cnt_ff;
      prod_in      = prod_ff;
      pad_in       = pad_ff;
      padch_in     = padch_ff;
      text_we      = 1'b0;
      text_wd      = sdf_pkg::CHAR_MINUS;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (ctrl.go) begin
         unique case (ctrl.act)
            sdf_pkg::ACT_LOAD: begin
               neg_in   = req_data.value[31];
               mag_in   = req_data.value[31] ? (32'd0 - req_data.value) : req_data.value;
               width_in = (req_data.min_width > 6'(sdf_pkg::MAX_WIDTH)) ?
                          6'(sdf_pkg::MAX_WIDTH) : req_data.min_width;
               padch_in = req_data.pad_char;
               cnt_in   = '0;
            end
            sdf_pkg::ACT_MUL: begin
               prod_in = 64'(mag_ff) * 64'(sdf_pkg::RECIP);
            end
            sdf_pkg::ACT_DIGIT: begin
               text_we = 1'b1;
               text_wd = sdf_pkg::CHAR_ZERO + {4'd0, remd[3:0]};
               mag_in  = quot;
               cnt_in  = cnt_ff + sdf_pkg::CNT_W'(1);
            end
            sdf_pkg::ACT_SIGN: begin
               if (neg_ff) begin
                  text_we = 1'b1;
                  text_wd = sdf_pkg::CHAR_MINUS;
                  cnt_in  = cnt_ff + sdf_pkg::CNT_W'(1);
               end
            end
            sdf_pkg::ACT_PADS: begin
               pad_in = (width_ff > cnt_ext) ? (width_ff - cnt_ext) : 6'd0;
            end
            sdf_pkg::ACT_OUT_PAD: begin
               // text always follows, so a pad is never last
               rsp_in       = '{padch_ff, 1'b0};
               rsp_valid_in = 1'b1;
               pad_in       = pad_ff - 6'd1;
            end
            sdf_pkg::ACT_OUT_TXT: begin
               rsp_in       = '{text_ff[rd_idx], cnt_ff == sdf_pkg::CNT_W'(1)};
               rsp_valid_in = 1'b1;
               cnt_in       = rd_idx;
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && !rsp_ready;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      width_ff <= width_in;
      cnt_ff   <= cnt_in;
      prod_ff  <= prod_in;
      pad_ff   <= pad_in;
      padch_ff <= padch_in;
      rsp_ff   <= rsp_in;
      if (text_we) begin
         text_ff[cnt_ff] <= text_wd;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== design/signed_decimal_formatter.sv =====
// Top level of the signed decimal formatter: sequencer plus datapath.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   req_data  (value, min_width, pad_char)
//   rsp      out        rsp_valid / rsp_ready   rsp_data  (char_out, last)
//
// The digit loop shares one 32x32 reciprocal multiplier over two steps per digit;
// the output emits one char a cycle while the output slot is free (not stalled).
// Synchronous reset clears the step counter and the output valid.
// A stalled output holds the sequencer in its emit step; the last char may still
// wait in the output register while the next item is accepted.
`include "signed_decimal_formatter_macros.svh"

module signed_decimal_formatter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sdf_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sdf_pkg::rsp_type  rsp_data
);

   sdf_pkg::ctrl_type ctrl;
   sdf_pkg::stat_type stat;

   sdf_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .stat      (stat),
      .req_ready (req_ready),
      .ctrl      (ctrl)
   );

   sdf_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .stat      (stat)
   );

   `SDF_ASSERT_NEXT(a_accept_then_mul, req_valid && req_ready, ctrl.act == sdf_pkg::ACT_MUL, "accepted item did not start the divide loop")
   `SDF_ASSERT_NOW(a_last_is_digit, rsp_valid && rsp_data.last, rsp_data.char_out >= sdf_pkg::CHAR_ZERO && rsp_data.char_out <= sdf_pkg::CHAR_NINE, "final char is not a digit")
   `SDF_ASSERT_NOW(a_emit_needs_slot, ctrl.go && (ctrl.act == sdf_pkg::ACT_OUT_PAD || ctrl.act == sdf_pkg::ACT_OUT_TXT), stat.slot_free, "char emitted over an untaken item")

endmodule

// ===== test/signed_decimal_formatter_test.sv =====
// Self-checking testbench of the signed decimal formatter: directed and random items.
`timescale 1ns / 1ps

class decimal_text_board;
   sdf_pkg::rsp_type pending_chars[$];
   int               failures;

   function new();
      failures = 0;
   endfunction

   // Format one accepted item and queue the characters it should produce.
   function void note_item(sdf_pkg::req_type item);
      logic [31:0]      magnitude;
      logic [31:0]      remainder;
      logic [7:0]       text[$];
      logic             negative;
      int               field_width;
      int               pad_count;
      int               total;
      sdf_pkg::rsp_type entry;
      negative  = item.value[31];
      magnitude = negative ? (32'd0 - item.value) : item.value;
      do begin
         remainder = magnitude % 32'd10;
         text.push_front(sdf_pkg::CHAR_ZERO + remainder[7:0]);
         magnitude = magnitude / 32'd10;
      end while (magnitude != 32'd0);
      if (negative)
         text.push_front(sdf_pkg::CHAR_MINUS);
      field_width = (item.min_width > sdf_pkg::MAX_WIDTH) ?
                    sdf_pkg::MAX_WIDTH : int'(item.min_width);
      pad_count   = (field_width > text.size()) ? field_width - text.size() : 0;
      total       = pad_count + text.size();
      for (int k = 0; k < total; k++) begin
         entry.char_out = (k < pad_count) ? item.pad_char : text[k - pad_count];
         entry.last     = (k == total - 1);
         pending_chars.push_back(entry);
      end
   endfunction

   function void check_char(sdf_pkg::rsp_type got);
      sdf_pkg::rsp_type want;
      if (pending_chars.size() == 0) begin
         $error("char_out: no character expected, actual %h", got.char_out);
         failures++;
         return;
      end
      want = pending_chars.pop_front();
      if (got.char_out !== want.char_out) begin
         $error("char_out: expected %h, actual %h", want.char_out, got.char_out);
         failures++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, actual %0d", want.last, got.last);
         failures++;
      end
   endfunction

   function int outstanding();
      return pending_chars.size();
   endfunction
endclass

module signed_decimal_formatter_test;

   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 100;
   localparam int PHASE_ITEMS  = 84;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   sdf_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   sdf_pkg::rsp_type rsp_data;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int holds_asked    = 0;

   decimal_text_board board;

   signed_decimal_formatter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin
      #10ms;
      $display("FAILED: results differ");
      $finish;
   end

   // Offer one item after a random gap; valid stays high for back-to-back items.
   task automatic send_item(sdf_pkg::req_type item);
      int gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      board.note_item(item);
   endtask

   function automatic sdf_pkg::req_type make_item(logic [31:0] value, logic [5:0] width,
                                                  logic [7:0] pad);
      sdf_pkg::req_type item;
      item.value     = value;
      item.min_width = width;
      item.pad_char  = pad;
      return item;
   endfunction

   // Mix of full-range values, small ones and digit-count boundaries.
   function automatic logic [31:0] random_value();
      logic [31:0] power;
      logic [31:0] pick;
      int          exponent;
      case ($urandom_range(5))
         0: pick = $urandom_range(99);
         1: begin
            exponent = $urandom_range(9);
            power    = 32'd1;
            repeat (exponent) power = power * 32'd10;
            pick = power - $urandom_range(1);
         end
         2: begin
            case ($urandom_range(3))
               0: pick = 32'h7FFF_FFFF;
               1: pick = 32'h8000_0000;
               2: pick = 32'h0;
               default: pick = 32'hFFFF_FFFF;
            endcase
         end
         default: pick = $urandom;
      endcase
      if (pick != 32'h8000_0000 && $urandom_range(1) == 1)
         pick = 32'd0 - pick;
      return pick;
   endfunction

   function automatic logic [5:0] random_width();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55)
         return 6'($urandom_range(12));
      else if (roll < 85)
         return 6'($urandom_range(32, 13));
      return 6'($urandom_range(63, 33));
   endfunction

   // Receiver: random stalls, plus a long hold-off whenever one is asked for.
   initial begin : receiver
      int holds_done;
      int hold_left;
      holds_done = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (holds_done != holds_asked) begin
            holds_done = holds_asked;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_char(rsp_data);
   end

   initial begin : stimulus
      int idle_plan[5];
      int stall_plan[5];
      board = new();
      idle_plan  = '{0, 62, 0, 21, 0};
      stall_plan = '{0, 0, 62, 21, 0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, zero, sign handling, width saturation and overflow.
      send_item(make_item(32'd0, 6'd0, 8'h20));
      send_item(make_item(32'd0, 6'd1, 8'h2A));
      send_item(make_item(32'd0, 6'd32, 8'h30));
      send_item(make_item(32'd7, 6'd3, 8'h00));
      send_item(make_item(32'hFFFF_FFFF, 6'd0, 8'hFF));
      send_item(make_item(32'hFFFF_FFFF, 6'd2, 8'h20));
      send_item(make_item(32'hFFFF_FFFF, 6'd3, 8'h30));
      send_item(make_item(32'd9, 6'd1, 8'h20));
      send_item(make_item(32'd10, 6'd1, 8'h20));
      send_item(make_item(32'hFFFF_FFF6, 6'd4, 8'h5F));
      send_item(make_item(32'h7FFF_FFFF, 6'd0, 8'h20));
      send_item(make_item(32'h7FFF_FFFF, 6'd10, 8'h20));
      send_item(make_item(32'h7FFF_FFFF, 6'd11, 8'h20));
      send_item(make_item(32'h8000_0000, 6'd0, 8'h20));
      send_item(make_item(32'h8000_0000, 6'd11, 8'h20));
      send_item(make_item(32'h8000_0000, 6'd12, 8'hAA));
      send_item(make_item(32'h8000_0000, 6'd32, 8'h55));
      send_item(make_item(32'd1000000000, 6'd33, 8'h2E));
      send_item(make_item(32'd0 - 32'd999999999, 6'd63, 8'hFF));
      send_item(make_item(32'd12345, 6'd40, 8'h00));
      send_item(make_item(32'd0 - 32'd1, 6'd32, 8'h80));
      send_item(make_item(32'd999999999, 6'd9, 8'h7F));

      for (int phase = 0; phase < 5; phase++) begin
         send_idle_pct  = idle_plan[phase];
         recv_stall_pct = stall_plan[phase];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // long output hold-off while items keep coming, so the input backs up
            if (phase == 0 && n == 20)
               holds_asked++;
            send_item(make_item(random_value(), random_width(), 8'($urandom_range(255))));
         end
      end
      req_valid <= 1'b0;

      while (board.outstanding() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.failures == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
